>>> hw/rtl/t3c_pkg.sv
// Shared types, constants and register codes for the type III compensator core.
// No dependencies; every other file of the block refers to it by scoped names.
package t3c_pkg;

  // Default values of the top-level parameters.
  localparam int unsigned OUTPUT_LIMIT_DEFAULT   = 13517;
  localparam int unsigned PERIOD_GAIN_DEFAULT    = 6981;
  localparam int unsigned PERIOD_FLOOR_DEFAULT   = 10000;
  localparam int unsigned PERIOD_CEIL_DEFAULT    = 40000;
  localparam int unsigned COEF_FRAC_BITS_DEFAULT = 14;

  // Fixed widths of the datapath.
  localparam int unsigned DATA_W      = 16;
  localparam int unsigned ERR_W       = DATA_W + 1;
  localparam int unsigned OPND_W      = DATA_W + 1;
  localparam int unsigned PROD_W      = 2 * OPND_W;
  localparam int unsigned ACC_W       = PROD_W + 2;
  localparam int unsigned VOLT_FRAC_W = 12;
  localparam int unsigned NUM_COEF    = 7;
  localparam int unsigned STEP_W      = 4;
  localparam int unsigned CFG_INDEX_W = 3;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_REFERENCE_VOLTAGE = 3'd0,
    CFG_COEF_X0           = 3'd1,
    CFG_COEF_X1           = 3'd2,
    CFG_COEF_X2           = 3'd3,
    CFG_COEF_X3           = 3'd4,
    CFG_COEF_Y1           = 3'd5,
    CFG_COEF_Y2           = 3'd6,
    CFG_COEF_Y3           = 3'd7
  } cfg_index_t;

  // Multiplier operand A: a coefficient or the period gain.
  typedef enum logic [2:0] {
    A_X0   = 3'd0,
    A_X1   = 3'd1,
    A_X2   = 3'd2,
    A_X3   = 3'd3,
    A_Y1   = 3'd4,
    A_Y2   = 3'd5,
    A_Y3   = 3'd6,
    A_GAIN = 3'd7
  } a_sel_t;

  // Multiplier operand B: the error, a history entry or the clamped output.
  typedef enum logic [2:0] {
    B_E   = 3'd0,
    B_EH0 = 3'd1,
    B_EH1 = 3'd2,
    B_EH2 = 3'd3,
    B_YH0 = 3'd4,
    B_YH1 = 3'd5,
    B_YH2 = 3'd6,
    B_Y   = 3'd7
  } b_sel_t;

  typedef enum logic [1:0] {
    ACC_NONE = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2
  } acc_op_t;

  // Sequencing of a microcode step.
  typedef enum logic [1:0] {
    SEQ_NEXT     = 2'd0,
    SEQ_WAIT_IN  = 2'd1,
    SEQ_WAIT_OUT = 2'd2
  } seq_op_t;

  typedef struct packed {
    seq_op_t           seq;
    logic [STEP_W-1:0] target;
    a_sel_t            a_sel;
    b_sel_t            b_sel;
    logic              mul_en;
    acc_op_t           acc_op;
    logic              clamp_en;
  } ucode_t;

  // Strobes from the sequencer to the datapath.
  typedef struct packed {
    logic    in_take;
    a_sel_t  a_sel;
    b_sel_t  b_sel;
    logic    mul_en;
    acc_op_t acc_op;
    logic    clamp_en;
    logic    out_load;
  } dp_ctl_t;

  // Configuration registers as seen by the datapath.
  typedef struct packed {
    logic [DATA_W-1:0]                reference_voltage;
    logic [NUM_COEF-1:0][DATA_W-1:0]  coef;
  } cfg_t;

  function automatic ucode_t mk_word(seq_op_t seq, logic [STEP_W-1:0] target, a_sel_t a,
                                     b_sel_t b, logic mul, acc_op_t acc, logic clamp);
    ucode_t w;
    w.seq      = seq;
    w.target   = target;
    w.a_sel    = a;
    w.b_sel    = b;
    w.mul_en   = mul;
    w.acc_op   = acc;
    w.clamp_en = clamp;
    return w;
  endfunction

endpackage

>>> hw/rtl/t3c_sequencer.sv
// Microcode sequencer: step counter, program table and jump logic.
// Depends on t3c_pkg for the control word and strobe types.
module t3c_sequencer (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              out_busy,
  output t3c_pkg::dp_ctl_t  ctl
);

  logic [t3c_pkg::STEP_W-1:0] step;
  logic [t3c_pkg::STEP_W-1:0] step_next;
  t3c_pkg::ucode_t            word;

  // Program: take an item, run seven products through the accumulator, clamp,
  // scale by the gain, then hand the result to the output register.
  always_comb begin
    case (step)
      4'd0:  word = t3c_pkg::mk_word(t3c_pkg::SEQ_WAIT_IN, 4'd1, t3c_pkg::A_X0,
                                     t3c_pkg::B_E, 1'b0, t3c_pkg::ACC_NONE, 1'b0);
      4'd1:  word = t3c_pkg::mk_word(t3c_pkg::SEQ_NEXT, 4'd0, t3c_pkg::A_X0,
                                     t3c_pkg::B_E, 1'b1, t3c_pkg::ACC_NONE, 1'b0);
      4'd2:  word = t3c_pkg::mk_word(t3c_pkg::SEQ_NEXT, 4'd0, t3c_pkg::A_X1,
                                     t3c_pkg::B_EH0, 1'b1, t3c_pkg::ACC_LOAD, 1'b0);
      4'd3:  word = t3c_pkg::mk_word(t3c_pkg::SEQ_NEXT, 4'd0, t3c_pkg::A_X2,
                                     t3c_pkg::B_EH1, 1'b1, t3c_pkg::ACC_ADD, 1'b0);
      4'd4:  word = t3c_pkg::mk_word(t3c_pkg::SEQ_NEXT, 4'd0, t3c_pkg::A_X3,
                                     t3c_pkg::B_EH2, 1'b1, t3c_pkg::ACC_ADD, 1'b0);
      4'd5:  word = t3c_pkg::mk_word(t3c_pkg::SEQ_NEXT, 4'd0, t3c_pkg::A_Y1,
                                     t3c_pkg::B_YH0, 1'b1, t3c_pkg::ACC_ADD, 1'b0);
      4'd6:  word = t3c_pkg::mk_word(t3c_pkg::SEQ_NEXT, 4'd0, t3c_pkg::A_Y2,
                                     t3c_pkg::B_YH1, 1'b1, t3c_pkg::ACC_ADD, 1'b0);
      4'd7:  word = t3c_pkg::mk_word(t3c_pkg::SEQ_NEXT, 4'd0, t3c_pkg::A_Y3,
                                     t3c_pkg::B_YH2, 1'b1, t3c_pkg::ACC_ADD, 1'b0);
      4'd8:  word = t3c_pkg::mk_word(t3c_pkg::SEQ_NEXT, 4'd0, t3c_pkg::A_X0,
                                     t3c_pkg::B_E, 1'b0, t3c_pkg::ACC_ADD, 1'b0);
      4'd9:  word = t3c_pkg::mk_word(t3c_pkg::SEQ_NEXT, 4'd0, t3c_pkg::A_X0,
                                     t3c_pkg::B_E, 1'b0, t3c_pkg::ACC_NONE, 1'b1);
      4'd10: word = t3c_pkg::mk_word(t3c_pkg::SEQ_NEXT, 4'd0, t3c_pkg::A_GAIN,
                                     t3c_pkg::B_Y, 1'b1, t3c_pkg::ACC_NONE, 1'b0);
      4'd11: word = t3c_pkg::mk_word(t3c_pkg::SEQ_WAIT_OUT, 4'd0, t3c_pkg::A_X0,
                                     t3c_pkg::B_E, 1'b0, t3c_pkg::ACC_NONE, 1'b0);
      default: word = t3c_pkg::mk_word(t3c_pkg::SEQ_WAIT_IN, 4'd1, t3c_pkg::A_X0,
                                       t3c_pkg::B_E, 1'b0, t3c_pkg::ACC_NONE, 1'b0);
    endcase
  end

  always_comb begin
    case (word.seq)
      t3c_pkg::SEQ_WAIT_IN:  step_next = in_valid ? word.target : step;
      t3c_pkg::SEQ_WAIT_OUT: step_next = out_busy ? step : word.target;
      default:               step_next = step + 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else begin
      step <= step_next;
    end
  end

  assign in_stall     = (word.seq != t3c_pkg::SEQ_WAIT_IN);
  assign ctl.in_take  = (word.seq == t3c_pkg::SEQ_WAIT_IN) && in_valid;
  assign ctl.a_sel    = word.a_sel;
  assign ctl.b_sel    = word.b_sel;
  assign ctl.mul_en   = word.mul_en;
  assign ctl.acc_op   = word.acc_op;
  assign ctl.clamp_en = word.clamp_en;
  assign ctl.out_load = (word.seq == t3c_pkg::SEQ_WAIT_OUT) && !out_busy;

endmodule

>>> hw/rtl/t3c_datapath.sv
// Datapath: error register, histories, shared multiplier, accumulator, clamps, output register.
// Depends on t3c_pkg; driven by the strobes of t3c_sequencer.
module t3c_datapath #(
  parameter int unsigned OUTPUT_LIMIT   = t3c_pkg::OUTPUT_LIMIT_DEFAULT,
  parameter int unsigned PERIOD_GAIN    = t3c_pkg::PERIOD_GAIN_DEFAULT,
  parameter int unsigned PERIOD_FLOOR   = t3c_pkg::PERIOD_FLOOR_DEFAULT,
  parameter int unsigned PERIOD_CEIL    = t3c_pkg::PERIOD_CEIL_DEFAULT,
  parameter int unsigned COEF_FRAC_BITS = t3c_pkg::COEF_FRAC_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  t3c_pkg::dp_ctl_t             ctl,
  input  t3c_pkg::cfg_t                cfg,
  input  logic [t3c_pkg::DATA_W-1:0]   voltage_sample,
  input  logic                         out_stall,
  output logic                         out_busy,
  output logic                         out_valid,
  output logic [t3c_pkg::DATA_W-1:0]   timer_period,
  output logic [t3c_pkg::DATA_W-2:0]   timer_compare,
  output logic [t3c_pkg::DATA_W-1:0]   compensator_out
);

  localparam int unsigned DW = t3c_pkg::DATA_W;
  localparam int unsigned PW = t3c_pkg::PROD_W;
  localparam int unsigned AW = t3c_pkg::ACC_W;
  localparam int unsigned SUM_W = PW - 2 - t3c_pkg::VOLT_FRAC_W + 1;

  logic signed [t3c_pkg::ERR_W-1:0]  e;
  logic signed [t3c_pkg::ERR_W-1:0]  eh0, eh1, eh2;
  logic [DW-1:0]                     yh0, yh1, yh2;
  logic [DW-1:0]                     y;
  logic signed [t3c_pkg::OPND_W-1:0] opnd_a, opnd_b;
  logic signed [PW-1:0]              prod;
  logic signed [PW-1:0]              prod_shift;
  logic signed [AW-1:0]              term;
  logic signed [AW-1:0]              acc;
  logic [DW-1:0]                     y_clamped;
  logic [SUM_W-1:0]                  period_sum;
  logic [DW-1:0]                     period;

  always_comb begin
    case (ctl.a_sel)
      t3c_pkg::A_GAIN: opnd_a = $signed({1'b0, DW'(PERIOD_GAIN)});
      default: begin
        opnd_a = $signed({cfg.coef[ctl.a_sel][DW-1], cfg.coef[ctl.a_sel]});
      end
    endcase
  end

  always_comb begin
    case (ctl.b_sel)
      t3c_pkg::B_E:   opnd_b = e;
      t3c_pkg::B_EH0: opnd_b = eh0;
      t3c_pkg::B_EH1: opnd_b = eh1;
      t3c_pkg::B_EH2: opnd_b = eh2;
      t3c_pkg::B_YH0: opnd_b = $signed({1'b0, yh0});
      t3c_pkg::B_YH1: opnd_b = $signed({1'b0, yh1});
      t3c_pkg::B_YH2: opnd_b = $signed({1'b0, yh2});
      default:        opnd_b = $signed({1'b0, y});
    endcase
  end

  // Arithmetic shift floors the product back to the voltage format.
  assign prod_shift = prod >>> COEF_FRAC_BITS;
  assign term = {{(AW - PW){prod_shift[PW-1]}}, prod_shift};

  always_comb begin
    if (acc >= $signed(AW'(OUTPUT_LIMIT))) begin
      y_clamped = DW'(OUTPUT_LIMIT);
    end else if (acc <= $signed(AW'(0))) begin
      y_clamped = '0;
    end else begin
      y_clamped = acc[DW-1:0];
    end
  end

  // The gain product of two non-negative 16-bit values fits in the low bits of prod.
  assign period_sum = SUM_W'(prod[PW-3:t3c_pkg::VOLT_FRAC_W]) + SUM_W'(PERIOD_FLOOR);

  always_comb begin
    if (period_sum > SUM_W'(PERIOD_CEIL)) begin
      period = DW'(PERIOD_CEIL);
    end else if (period_sum < SUM_W'(PERIOD_FLOOR)) begin
      period = DW'(PERIOD_FLOOR);
    end else begin
      period = period_sum[DW-1:0];
    end
  end

  assign out_busy = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (ctl.in_take) begin
      e <= $signed({1'b0, voltage_sample}) - $signed({1'b0, cfg.reference_voltage});
    end
    if (ctl.mul_en) begin
      prod <= opnd_a * opnd_b;
    end
    case (ctl.acc_op)
      t3c_pkg::ACC_LOAD: acc <= term;
      t3c_pkg::ACC_ADD:  acc <= acc + term;
      default:           acc <= acc;
    endcase
    if (ctl.clamp_en) begin
      y <= y_clamped;
    end
    if (ctl.out_load) begin
      timer_period    <= period;
      timer_compare   <= period[DW-1:1];
      compensator_out <= y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eh0       <= '0;
      eh1       <= '0;
      eh2       <= '0;
      yh0       <= '0;
      yh1       <= '0;
      yh2       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.clamp_en) begin
        eh2 <= eh1;
        eh1 <= eh0;
        eh0 <= e;
        yh2 <= yh1;
        yh1 <= yh0;
        yh0 <= y_clamped;
      end
      if (ctl.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> hw/rtl/type3_compensator_pwm_period_core.sv
// Top level of the type III compensator that sets a PWM timer period.
// Depends on t3c_pkg, t3c_sequencer and t3c_datapath.
//
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+-------------------------------------------------
//  input    | in_valid / in_stall        | voltage_sample[15:0]
//  output   | out_valid / out_stall      | timer_period[15:0], timer_compare[14:0],
//           |                            | compensator_out[15:0]
//  config   | cfg_wr_en, cfg_index[2:0]  | cfg_data[15:0]
//
// An item occupies 12 program steps, from taking its sample to loading its result into the
// output register: one to take the sample, seven coefficient products issued through the
// single shared 17x17 multiplier plus the final accumulation (eight steps), one clamp step,
// one gain product and one step that loads the output register. A new item is accepted
// only once the previous result has been loaded into the output register. The result waits
// in the output register while out_stall is high; the next item is accepted and computed
// meanwhile and holds in the last step until the register frees up.
// Reset (rst, synchronous) clears the histories, the step counter and the output valid,
// and loads the default coefficients and a zero reference.
module type3_compensator_pwm_period_core #(
  parameter int unsigned OUTPUT_LIMIT   = t3c_pkg::OUTPUT_LIMIT_DEFAULT,
  parameter int unsigned PERIOD_GAIN    = t3c_pkg::PERIOD_GAIN_DEFAULT,
  parameter int unsigned PERIOD_FLOOR   = t3c_pkg::PERIOD_FLOOR_DEFAULT,
  parameter int unsigned PERIOD_CEIL    = t3c_pkg::PERIOD_CEIL_DEFAULT,
  parameter int unsigned COEF_FRAC_BITS = t3c_pkg::COEF_FRAC_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [t3c_pkg::DATA_W-1:0]        voltage_sample,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [t3c_pkg::DATA_W-1:0]        timer_period,
  output logic [t3c_pkg::DATA_W-2:0]        timer_compare,
  output logic [t3c_pkg::DATA_W-1:0]        compensator_out,
  input  logic                              cfg_wr_en,
  input  logic [t3c_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [t3c_pkg::DATA_W-1:0]        cfg_data
);

  t3c_pkg::cfg_t    cfg;
  t3c_pkg::dp_ctl_t ctl;
  logic             out_busy;

  // Configuration registers. Every index of the port names a register, so no write
  // falls outside the list.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reference_voltage <= '0;
      cfg.coef[0]           <= 16'hE570;  // -6800
      cfg.coef[1]           <= 16'd6135;
      cfg.coef[2]           <= 16'd6798;
      cfg.coef[3]           <= 16'hE807;  // -6137
      cfg.coef[4]           <= 16'd18236;
      cfg.coef[5]           <= 16'hFD78;  // -648
      cfg.coef[6]           <= 16'hFB4D;  // -1203
    end else if (cfg_wr_en) begin
      case (cfg_index)
        t3c_pkg::CFG_REFERENCE_VOLTAGE: cfg.reference_voltage <= cfg_data;
        t3c_pkg::CFG_COEF_X0:           cfg.coef[0]           <= cfg_data;
        t3c_pkg::CFG_COEF_X1:           cfg.coef[1]           <= cfg_data;
        t3c_pkg::CFG_COEF_X2:           cfg.coef[2]           <= cfg_data;
        t3c_pkg::CFG_COEF_X3:           cfg.coef[3]           <= cfg_data;
        t3c_pkg::CFG_COEF_Y1:           cfg.coef[4]           <= cfg_data;
        t3c_pkg::CFG_COEF_Y2:           cfg.coef[5]           <= cfg_data;
        t3c_pkg::CFG_COEF_Y3:           cfg.coef[6]           <= cfg_data;
        default:                        cfg                   <= cfg;
      endcase
    end
  end

  // The sequencer steps through the program and drives the datapath strobes.
  t3c_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_busy (out_busy),
    .ctl      (ctl)
  );

  // The datapath holds the histories, the shared multiplier and the output register.
  t3c_datapath #(
    .OUTPUT_LIMIT   (OUTPUT_LIMIT),
    .PERIOD_GAIN    (PERIOD_GAIN),
    .PERIOD_FLOOR   (PERIOD_FLOOR),
    .PERIOD_CEIL    (PERIOD_CEIL),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .cfg             (cfg),
    .voltage_sample  (voltage_sample),
    .out_stall       (out_stall),
    .out_busy        (out_busy),
    .out_valid       (out_valid),
    .timer_period    (timer_period),
    .timer_compare   (timer_compare),
    .compensator_out (compensator_out)
  );

endmodule
